/* hdl/b2da_pkg.sv */
`default_nettype none
package b2da_pkg;

  // Width of the input value and of its non-negative magnitude
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MAG_W   = VALUE_W - 1;

  // Width of one output character
  localparam int unsigned CHAR_W = 6;

  // Size of the digit buffer; upper digits beyond it are dropped
  localparam int unsigned MAX_DIGITS = 10;

  // BCD digits needed to hold any non-negative 32-bit value
  localparam int unsigned NUM_BCD = 10;

  localparam int unsigned KEEP_DIGITS = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
  localparam int unsigned IDX_W       = $clog2(NUM_BCD);
  localparam int unsigned CNT_W       = $clog2(MAG_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // Depth of the queue between the front and the converter
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_EMIT
  } conv_state_t;

  // Head of the job queue as seen by the converter
  typedef struct packed {
    logic             valid;
    logic [MAG_W-1:0] mag;
  } job_t;

endpackage
`default_nettype wire

/* hdl/binary_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII character stream.
//
// Input channel: drive in_value and raise in_push; the transaction is taken
// at a clock edge where in_full is low. A negative value is taken and dropped.
// Result channel: while out_empty is low, out_digit_char holds one ASCII digit
// ('0'..'9'), most significant first, leading zeros suppressed; zero gives a
// single '0'. out_last_digit marks the least significant digit. Raise out_pop
// to take the character.
// An accepted value is offered to the converter in the cycle after it is taken.
// The converter dequeues it, runs one double-dabble shift per magnitude bit and
// scans for the leading digit, then gives one character per cycle while the
// receiver takes them, and dequeues the next value after the last of 1 to 10 digits.
// A two-entry queue ahead of the converter keeps taking values while it works.
// When the receiver stalls, the current character holds and the converter
// waits; the queue then fills and in_full rises.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`default_nettype none
module binary_to_decimal_ascii (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [b2da_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit
);
  import b2da_pkg::*;

  job_t job;
  logic job_pop;

  b2da_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .job      (job),
    .job_pop  (job_pop)
  );

  b2da_conv u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (job),
    .job_pop        (job_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  // Any character on the output is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_digit_char >= ASCII_ZERO) && (out_digit_char <= ASCII_ZERO + 6'd9))
    else $error("output character is not a decimal digit");

  // A full queue always presents a job to the converter
  a_full_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> job.valid)
    else $error("queue full but no job offered");

  // The converter only dequeues a job that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job.valid)
    else $error("job dequeued from an empty queue");

  // Reset leaves no character pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("output not empty after reset");

endmodule
`default_nettype wire

/* hdl/b2da_front.sv */
`default_nettype none
module b2da_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [b2da_pkg::VALUE_W-1:0]   in_value,
  output b2da_pkg::job_t                      job,
  input  wire logic                           job_pop
);
  import b2da_pkg::*;

  logic [MAG_W-1:0]  q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              keep;
  logic              pop_ok;

  assign in_full = (count_r == QCNT_W'(QUEUE_DEPTH));

  // Negative values produce no characters: accept and drop them here
  assign keep   = in_push && !in_full && !in_value[VALUE_W-1];
  assign pop_ok = job_pop && (count_r != '0);

  assign job.valid = (count_r != '0);
  assign job.mag   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (keep) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (keep && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (!keep && pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wr_ptr_r] <= in_value[MAG_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* hdl/b2da_conv.sv */
`default_nettype none
module b2da_conv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire b2da_pkg::job_t                job,
  output logic                               job_pop,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [b2da_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                               out_last_digit
);
  import b2da_pkg::*;

  conv_state_t       state_r, state_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [3:0]        bcd_r [NUM_BCD];
  logic [3:0]        bcd_nxt [NUM_BCD];
  logic [3:0]        adj [NUM_BCD];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  msd;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              pop_ok;

  assign pop_ok         = out_pop && out_valid_r;
  assign out_empty      = !out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // Double dabble: bump every digit of five or more by three before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // Most significant nonzero digit, clipped to the digit buffer
  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_BCD; i++) begin
      if (bcd_r[i] != 4'd0) begin
        msd = IDX_W'(i);
      end
    end
    if (msd > IDX_W'(KEEP_DIGITS - 1)) begin
      msd = IDX_W'(KEEP_DIGITS - 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    job_pop       = 1'b0;
    out_valid_nxt = pop_ok ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job.valid) begin
          job_pop   = 1'b1;
          mag_nxt   = job.mag;
          cnt_nxt   = '0;
          for (int i = 0; i < NUM_BCD; i++) begin
            bcd_nxt[i] = 4'd0;
          end
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_nxt[0] = {adj[0][2:0], mag_r[MAG_W-1]};
        for (int i = 1; i < NUM_BCD; i++) begin
          bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
        end
        mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt   = msd;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Load the next character when the output register is free or drains now
        if (!out_valid_r || pop_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {2'b00, bcd_r[idx_r]};
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
